// File: rtl/tpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants for the triangle projection core
// Fixed-point widths, register codes, result codes and rotation helpers.
// ----------------------------------------------------------------------------
package tpc_pkg;

	// camera-space coordinate, wide enough for three chained rotations
	localparam int unsigned COORD_W = 40;
	// projection numerator: (x + z) * size * 128
	localparam int unsigned NUM_W   = 61;
	// screen coordinate, Q16.8
	localparam int unsigned SCR_W   = 24;
	// quotient bits resolved by the divider before saturation
	localparam int unsigned QB      = 25;
	// divider stages: magnitude, range check, one stage per bit, saturation
	localparam int unsigned DIV_STG = QB + 3;
	// front end: offset, three rotations, numerator
	localparam int unsigned FE_STG  = 5;
	// all pipeline stages: front end, divider, area products, output
	localparam int unsigned NSTG    = FE_STG + DIV_STG + 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NUM_W-1:0]   num_t;
	typedef logic signed [SCR_W-1:0]   scr_t;
	typedef logic signed [15:0]        trig_t;

	// near plane, 0.1 in Q16.16 rounded down
	localparam coord_t NEAR_Z = coord_t'(6553);
	localparam scr_t   SCR_MAX = {1'b0, {(SCR_W-1){1'b1}}};
	localparam scr_t   SCR_MIN = {1'b1, {(SCR_W-1){1'b0}}};

	localparam logic [31:0] TRIG_RESET = 32'h4000_0000;
	localparam logic [12:0] WIDTH_RESET  = 13'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;

	typedef enum logic [2:0] {
		REG_CAM_POS_X   = 3'd0,
		REG_CAM_POS_Y   = 3'd1,
		REG_CAM_POS_Z   = 3'd2,
		REG_PITCH_TRIG  = 3'd3,
		REG_YAW_TRIG    = 3'd4,
		REG_ROLL_TRIG   = 3'd5,
		REG_SCREEN_W    = 3'd6,
		REG_SCREEN_H    = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_DRAW = 2'd0,
		ST_BACK = 2'd1,
		ST_CLIP = 2'd2
	} status_t;

	// floor((a*c + b*s) / 2^14)
	function automatic coord_t rot_add(coord_t a, coord_t b, trig_t c, trig_t s);
		logic signed [56:0] p;
		p = 57'(a) * 57'(c) + 57'(b) * 57'(s);
		return coord_t'(p[53:14]);
	endfunction

	// floor((a*c - b*s) / 2^14)
	function automatic coord_t rot_sub(coord_t a, coord_t b, trig_t c, trig_t s);
		logic signed [56:0] p;
		p = 57'(a) * 57'(c) - 57'(b) * 57'(s);
		return coord_t'(p[53:14]);
	endfunction

endpackage
`default_nettype wire

// File: rtl/tpc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_div: pipelined floor division with Q16.8 saturation
// Restoring long division, one quotient bit per stage, stalled per stage.
// ----------------------------------------------------------------------------
module tpc_div
	import tpc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic [DIV_STG-1:0] en,
	input  wire num_t               num,
	input  wire coord_t             den,
	output scr_t                    quo
);

	localparam int unsigned RW = NUM_W + 5;

	logic [NUM_W-1:0]   rem_s [DIV_STG-1];
	logic [QB-1:0]      q_s   [DIV_STG-1];
	logic [COORD_W-1:0] d_s   [DIV_STG-1];
	logic               neg_s [DIV_STG-1];
	logic               ovf_s [DIV_STG-1];
	scr_t               quo_s;

	// sign and magnitude
	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_s[0] <= num[NUM_W-1];
			rem_s[0] <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			d_s[0]   <= den;
			q_s[0]   <= '0;
			ovf_s[0] <= 1'b0;
		end
	end

	// quotient would not fit in QB bits
	always_ff @(posedge clk) begin
		if (en[1]) begin
			neg_s[1] <= neg_s[0];
			rem_s[1] <= rem_s[0];
			d_s[1]   <= d_s[0];
			q_s[1]   <= '0;
			ovf_s[1] <= RW'(rem_s[0]) >= (RW'(d_s[0]) << QB);
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 2; k < DIV_STG - 1; k++) begin : g_bit
		localparam int unsigned BI = DIV_STG - 2 - k;
		logic [RW-1:0] trial;
		logic          ge;
		assign trial = RW'(rem_s[k-1]) - (RW'(d_s[k-1]) << BI);
		assign ge    = !trial[RW-1];
		always_ff @(posedge clk) begin
			if (en[k]) begin
				neg_s[k]    <= neg_s[k-1];
				d_s[k]      <= d_s[k-1];
				ovf_s[k]    <= ovf_s[k-1];
				rem_s[k]    <= ge ? trial[NUM_W-1:0] : rem_s[k-1];
				q_s[k]      <= q_s[k-1] | (QB'(ge) << BI);
			end
		end
	end

	// round toward minus infinity and saturate
	logic [QB:0] mag_up;
	assign mag_up = (QB+1)'(q_s[DIV_STG-2])
		+ (QB+1)'(rem_s[DIV_STG-2] != '0);

	always_ff @(posedge clk) begin
		if (en[DIV_STG-1]) begin
			if (neg_s[DIV_STG-2]) begin
				if (ovf_s[DIV_STG-2] || mag_up > (QB+1)'(2**(SCR_W-1)))
					quo_s <= SCR_MIN;
				else
					quo_s <= scr_t'(-mag_up[SCR_W-1:0]);
			end else begin
				if (ovf_s[DIV_STG-2] || q_s[DIV_STG-2] > QB'(2**(SCR_W-1) - 1))
					quo_s <= SCR_MAX;
				else
					quo_s <= scr_t'(q_s[DIV_STG-2][SCR_W-1:0]);
			end
		end
	end

	assign quo = quo_s;

endmodule
`default_nettype wire

// File: rtl/triangle_project_and_cull_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_project_and_cull_core: camera transform, projection and culling
// Projects a world-space triangle to Q16.8 screen space and classifies it.
// ----------------------------------------------------------------------------
// Accepts one triangle per clock while the output side does not stall and
// delivers one result per triangle, in order. Most of the pipeline lies in
// the six parallel restoring dividers, which resolve one quotient bit per
// stage. Each stage holds its item only while the stage after it is full and
// stalled, so bubbles close up under back-pressure. Registers are written
// through the cfg port, which is always ready; write them only while no
// triangle is in flight.
module triangle_project_and_cull_core
	import tpc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (32 bits each)
	input  wire logic [287:0] s_tdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// s0_x, s0_y, s1_x, s1_y, s2_x, s2_y (24 bits each)
	output logic [143:0]      m_tdata,
	// status
	output logic [1:0]        m_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	// configuration registers
	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic [31:0]        pitch_q, yaw_q, roll_q;
	logic [12:0]        width_q, height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q  <= '0;
			cam_y_q  <= '0;
			cam_z_q  <= '0;
			pitch_q  <= TRIG_RESET;
			yaw_q    <= TRIG_RESET;
			roll_q   <= TRIG_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CAM_POS_X:  cam_x_q  <= cfg_data;
				REG_CAM_POS_Y:  cam_y_q  <= cfg_data;
				REG_CAM_POS_Z:  cam_z_q  <= cfg_data;
				REG_PITCH_TRIG: pitch_q  <= cfg_data;
				REG_YAW_TRIG:   yaw_q    <= cfg_data;
				REG_ROLL_TRIG:  roll_q   <= cfg_data;
				REG_SCREEN_W:   width_q  <= cfg_data[12:0];
				REG_SCREEN_H:   height_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// stage valids and per-stage load enables
	logic [NSTG-1:0] v_q;
	logic [NSTG-1:0] en;

	always_comb begin
		en[NSTG-1] = !v_q[NSTG-1] || m_tready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign s_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0])
				v_q[0] <= s_tvalid;
			for (int k = 1; k < NSTG; k++) begin
				if (en[k])
					v_q[k] <= v_q[k-1];
			end
		end
	end

	// stage 1: offset by camera position
	coord_t x_s1 [3], y_s1 [3], z_s1 [3];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int j = 0; j < 3; j++) begin
				x_s1[j] <= coord_t'($signed(s_tdata[96*j +: 32])) - coord_t'(cam_x_q);
				y_s1[j] <= coord_t'($signed(s_tdata[96*j+32 +: 32])) - coord_t'(cam_y_q);
				z_s1[j] <= coord_t'($signed(s_tdata[96*j+64 +: 32])) - coord_t'(cam_z_q);
			end
		end
	end

	// stage 2: rotate about z
	coord_t x_s2 [3], y_s2 [3], z_s2 [3];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int j = 0; j < 3; j++) begin
				x_s2[j] <= rot_add(x_s1[j], y_s1[j], roll_q[31:16], roll_q[15:0]);
				y_s2[j] <= rot_sub(y_s1[j], x_s1[j], roll_q[31:16], roll_q[15:0]);
				z_s2[j] <= z_s1[j];
			end
		end
	end

	// stage 3: rotate about y
	coord_t x_s3 [3], y_s3 [3], z_s3 [3];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int j = 0; j < 3; j++) begin
				z_s3[j] <= rot_add(z_s2[j], x_s2[j], yaw_q[31:16], yaw_q[15:0]);
				x_s3[j] <= rot_sub(x_s2[j], z_s2[j], yaw_q[31:16], yaw_q[15:0]);
				y_s3[j] <= y_s2[j];
			end
		end
	end

	// stage 4: rotate about x
	coord_t x_s4 [3], y_s4 [3], z_s4 [3];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int j = 0; j < 3; j++) begin
				y_s4[j] <= rot_add(y_s3[j], z_s3[j], pitch_q[31:16], pitch_q[15:0]);
				z_s4[j] <= rot_sub(z_s3[j], y_s3[j], pitch_q[31:16], pitch_q[15:0]);
				x_s4[j] <= x_s3[j];
			end
		end
	end

	// stage 5: near test and projection numerators
	num_t       nx_s5 [3], ny_s5 [3];
	coord_t     d_s5  [3];
	logic [2:0] clip_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int j = 0; j < 3; j++) begin
				nx_s5[j]   <= (num_t'(x_s4[j] + z_s4[j]) * num_t'({1'b0, width_q})) <<< 7;
				ny_s5[j]   <= (num_t'(y_s4[j] + z_s4[j]) * num_t'({1'b0, height_q})) <<< 7;
				d_s5[j]    <= z_s4[j];
				clip_s5[j] <= z_s4[j] <= NEAR_Z;
			end
		end
	end

	// dividers, one per screen coordinate
	scr_t sx [3], sy [3];

	for (genvar j = 0; j < 3; j++) begin : g_vtx
		tpc_div u_div_x (
			.clk (clk),
			.en  (en[FE_STG +: DIV_STG]),
			.num (nx_s5[j]),
			.den (d_s5[j]),
			.quo (sx[j])
		);
		tpc_div u_div_y (
			.clk (clk),
			.en  (en[FE_STG +: DIV_STG]),
			.num (ny_s5[j]),
			.den (d_s5[j]),
			.quo (sy[j])
		);
	end

	// clip flags travel beside the dividers
	logic [2:0] clip_q [DIV_STG];

	always_ff @(posedge clk) begin
		if (en[FE_STG])
			clip_q[0] <= clip_s5;
		for (int k = 1; k < DIV_STG; k++) begin
			if (en[FE_STG + k])
				clip_q[k] <= clip_q[k-1];
		end
	end

	// area products
	localparam int unsigned AS = FE_STG + DIV_STG;
	logic signed [2*SCR_W+1:0] pa_sa, pb_sa;
	scr_t                      sx_sa [3], sy_sa [3];
	logic                      clip_sa;

	always_ff @(posedge clk) begin
		if (en[AS]) begin
			pa_sa   <= (2*SCR_W+2)'((SCR_W+1)'(sx[1]) - (SCR_W+1)'(sx[0]))
				* (2*SCR_W+2)'((SCR_W+1)'(sy[2]) - (SCR_W+1)'(sy[0]));
			pb_sa   <= (2*SCR_W+2)'((SCR_W+1)'(sy[1]) - (SCR_W+1)'(sy[0]))
				* (2*SCR_W+2)'((SCR_W+1)'(sx[2]) - (SCR_W+1)'(sx[0]));
			clip_sa <= |clip_q[DIV_STG-1];
			for (int j = 0; j < 3; j++) begin
				sx_sa[j] <= sx[j];
				sy_sa[j] <= sy[j];
			end
		end
	end

	// output register: classify
	logic [143:0] data_so;
	status_t      status_so;
	logic signed [2*SCR_W+2:0] area;

	assign area = (2*SCR_W+3)'(pa_sa) - (2*SCR_W+3)'(pb_sa);

	always_ff @(posedge clk) begin
		if (en[NSTG-1]) begin
			if (clip_sa) begin
				data_so   <= '0;
				status_so <= ST_CLIP;
			end else begin
				data_so   <= {sy_sa[2], sx_sa[2], sy_sa[1], sx_sa[1], sy_sa[0], sx_sa[0]};
				status_so <= area[2*SCR_W+2] ? ST_DRAW : ST_BACK;
			end
		end
	end

	assign m_tdata  = data_so;
	assign m_tuser  = status_so;
	assign m_tvalid = v_q[NSTG-1];

`ifndef SYNTH
	// a clipped result carries no coordinates
	a_clip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_CLIP |-> m_tdata == '0)
		else $error("clipped result with coordinates");

	// an empty output stage never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled behind empty output");

	// a drawn triangle has distinct first and second vertices
	a_draw_area: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_DRAW |->
			(m_tdata[23:0] != m_tdata[71:48] || m_tdata[47:24] != m_tdata[95:72]))
		else $error("degenerate triangle marked for drawing");

	// a stalled output stays valid and holds its data
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
